@@ design/jdm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the joystick direction and magnitude block.
// No dependencies.
package jdm_pkg;

    localparam int DZ_W  = 8;
    localparam int MAG_W = 8;

    localparam logic [DZ_W-1:0]  DEAD_ZONE_RESET = 8'd20;
    localparam logic [MAG_W-1:0] MAG_MAX         = 8'd255;

    typedef enum logic [2:0] {
        STICK_NONE  = 3'd0,
        STICK_RIGHT = 3'd1,
        STICK_LEFT  = 3'd2,
        STICK_UP    = 3'd3,
        STICK_DOWN  = 3'd4
    } dir_t;

    // Classification results that ride along the root chain
    typedef struct packed {
        dir_t dir;
        logic centred;
        logic pressed;
    } side_t;

endpackage

@@ design/jdm_front.sv @@
`timescale 1ns / 1ps
// Front stage: centers the samples, classifies direction, forms x*x + y*y.
// Depends on jdm_pkg.
module jdm_front #(
    parameter int SAMPLE_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         valid_in,
    input  logic [SAMPLE_BITS-1:0]       hor,
    input  logic [SAMPLE_BITS-1:0]       ver,
    input  logic                         button,
    input  logic [jdm_pkg::DZ_W-1:0]     dz,
    output logic                         valid_out,
    output logic [2*SAMPLE_BITS-1:0]     sum_out,
    output jdm_pkg::side_t               side_out
);

    localparam int SUM_W = 2 * SAMPLE_BITS;
    localparam int CMP_W = (SAMPLE_BITS > jdm_pkg::DZ_W) ? SAMPLE_BITS : jdm_pkg::DZ_W;
    localparam logic [SAMPLE_BITS-1:0] MID = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

    logic                   valid_reg;
    logic [SUM_W-1:0]       sum_reg;
    jdm_pkg::side_t         side_reg;

    logic                   neg_x;
    logic                   neg_y;
    logic [SAMPLE_BITS-1:0] ax;
    logic [SAMPLE_BITS-1:0] ay;
    logic [CMP_W-1:0]       ax_c;
    logic [CMP_W-1:0]       ay_c;
    logic [CMP_W-1:0]       dz_c;
    logic [SUM_W-1:0]       sq_x;
    logic [SUM_W-1:0]       sq_y;
    logic [SUM_W-1:0]       sum_next;
    jdm_pkg::side_t         side_next;

    always_comb
    begin
        neg_x = ~hor[SAMPLE_BITS-1];
        neg_y = ~ver[SAMPLE_BITS-1];
        ax    = neg_x ? (MID - hor) : (hor - MID);
        ay    = neg_y ? (MID - ver) : (ver - MID);
        ax_c  = CMP_W'(ax);
        ay_c  = CMP_W'(ay);
        dz_c  = CMP_W'(dz);
        sq_x  = SUM_W'(ax) * SUM_W'(ax);
        sq_y  = SUM_W'(ay) * SUM_W'(ay);
        sum_next = sq_x + sq_y;

        side_next.centred = (ax_c < dz_c) && (ay_c < dz_c);
        side_next.pressed = ~button;
        side_next.dir     = jdm_pkg::STICK_NONE;
        if (!side_next.centred)
        begin
            if (ax_c >= ay_c)
            begin
                if (ax_c > dz_c)
                begin
                    side_next.dir = neg_x ? jdm_pkg::STICK_LEFT : jdm_pkg::STICK_RIGHT;
                end
            end
            else if (ay_c > dz_c)
            begin
                side_next.dir = neg_y ? jdm_pkg::STICK_DOWN : jdm_pkg::STICK_UP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= sum_next;
            side_reg <= side_next;
        end
    end

    assign valid_out = valid_reg;
    assign sum_out   = sum_reg;
    assign side_out  = side_reg;

endmodule

@@ design/jdm_root_cell.sv @@
`timescale 1ns / 1ps
// One cell of the square root chain: decides root bit BIT_IDX.
// Depends on jdm_pkg.
module jdm_root_cell #(
    parameter int SUM_W   = 16,
    parameter int ROOT_W  = 8,
    parameter int BIT_IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  logic [SUM_W-1:0]  rem_in,
    input  logic [ROOT_W-1:0] root_in,
    input  jdm_pkg::side_t    side_in,
    output logic              valid_out,
    output logic [SUM_W-1:0]  rem_out,
    output logic [ROOT_W-1:0] root_out,
    output jdm_pkg::side_t    side_out
);

    localparam int TW = SUM_W + 1;

    logic              valid_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    jdm_pkg::side_t    side_reg;

    logic [TW-1:0]     rem_ext;
    logic [TW-1:0]     trial;
    logic              take;
    logic [SUM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    // rem holds v - root^2; try setting this bit
    always_comb
    begin
        rem_ext   = TW'(rem_in);
        trial     = (TW'(root_in) << (BIT_IDX + 1)) + (TW'(1) << (2 * BIT_IDX));
        take      = rem_ext >= trial;
        rem_next  = take ? SUM_W'(rem_ext - trial) : rem_in;
        root_next = take ? (root_in | (ROOT_W'(1) << BIT_IDX)) : root_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign side_out  = side_reg;

endmodule

@@ design/joystick_direction_and_magnitude.sv @@
`timescale 1ns / 1ps
// Joystick classifier: one item per cycle while the output is not stalled; one front
// stage, then one square root cell per root bit. Input stall follows
// output stall when the output register is full. Depends on jdm_pkg,
// jdm_front and jdm_root_cell.
module joystick_direction_and_magnitude #(
    parameter int SAMPLE_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [jdm_pkg::DZ_W-1:0] dead_zone,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [SAMPLE_BITS-1:0]   horizontal_sample,
    input  logic [SAMPLE_BITS-1:0]   vertical_sample,
    input  logic                     button_level,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [2:0]               direction,
    output logic [jdm_pkg::MAG_W-1:0] magnitude,
    output logic                     centred,
    output logic                     button_pressed
);

    localparam int SUM_W  = 2 * SAMPLE_BITS;
    localparam int ROOT_W = SAMPLE_BITS;
    localparam int MW     = (ROOT_W > jdm_pkg::MAG_W) ? ROOT_W : jdm_pkg::MAG_W;

    logic [jdm_pkg::DZ_W-1:0] dead_zone_reg;
    logic                     en;

    logic                     valid_c [ROOT_W+1];
    logic [SUM_W-1:0]         rem_c   [ROOT_W+1];
    logic [ROOT_W-1:0]        root_c  [ROOT_W+1];
    jdm_pkg::side_t           side_c  [ROOT_W+1];
    logic [MW-1:0]            root_w;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= jdm_pkg::DEAD_ZONE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            dead_zone_reg <= dead_zone;
        end
    end

    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    jdm_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .valid_in (in_valid),
        .hor      (horizontal_sample),
        .ver      (vertical_sample),
        .button   (button_level),
        .dz       (dead_zone_reg),
        .valid_out(valid_c[0]),
        .sum_out  (rem_c[0]),
        .side_out (side_c[0])
    );

    assign root_c[0] = '0;

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_cell
        jdm_root_cell #(
            .SUM_W  (SUM_W),
            .ROOT_W (ROOT_W),
            .BIT_IDX(ROOT_W - 1 - i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .valid_in (valid_c[i]),
            .rem_in   (rem_c[i]),
            .root_in  (root_c[i]),
            .side_in  (side_c[i]),
            .valid_out(valid_c[i+1]),
            .rem_out  (rem_c[i+1]),
            .root_out (root_c[i+1]),
            .side_out (side_c[i+1])
        );
    end

    assign root_w         = MW'(root_c[ROOT_W]);
    assign out_valid      = valid_c[ROOT_W];
    assign direction      = side_c[ROOT_W].dir;
    assign centred        = side_c[ROOT_W].centred;
    assign button_pressed = side_c[ROOT_W].pressed;
    assign magnitude      = (root_w > MW'(jdm_pkg::MAG_MAX)) ? jdm_pkg::MAG_MAX
                                                             : root_w[jdm_pkg::MAG_W-1:0];

    a_centred_no_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && centred |-> direction == jdm_pkg::STICK_NONE)
        else $error("centred item carries a direction");

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(magnitude) && $stable(direction))
        else $error("stalled result lost or changed");

endmodule
